@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue.
package spq_pkg;

  localparam int TagW   = 16;
  localparam int PrioW  = 4;
  localparam int OrderW = 16;
  localparam int OccW   = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [PrioW-1:0]  prio;
    logic [OrderW-1:0] order;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } spq_cmd_t;

endpackage

@@ rtl/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// Stable priority queue: DEPTH jobs kept sorted by priority, then arrival order.
// Depends on spq_pkg and spq_cell.
//
// The queue takes one insert or remove transaction per cycle unless a held
// status stalls in_ready_o, and returns one status transaction for each
// through an output register. All DEPTH cells of the sorted chain compare
// against the new job at once, so an insert or a remove updates every cell together whatever the fill.
// Equal priorities leave in arrival order; an equal key goes behind the
// held entry. An insert into a full queue is dropped with status full, and a
// remove from an empty queue reports empty; out_tag and out_priority are zero
// except on removed. Occupancy shows the low five bits of the job count.
module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [TagW-1:0]   job_tag_i,
  input  logic [PrioW-1:0]  job_priority_i,
  input  logic [OrderW-1:0] arrival_order_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [TagW-1:0]   out_tag_o,
  output logic [PrioW-1:0]  out_priority_o,
  output logic [OccW-1:0]   occupancy_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [TagW-1:0] out_tag_q, out_tag_d;
  logic [PrioW-1:0] out_prio_q, out_prio_d;

  logic accept;
  logic full, empty;
  spq_cmd_t cmd;

  logic   [DEPTH-1:0] ahead;
  entry_t             cell_entry [DEPTH];
  logic   [CntW+OccW-1:0] cnt_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd.new_entry.tag   = job_tag_i;
    cmd.new_entry.prio  = job_priority_i;
    cmd.new_entry.order = arrival_order_i;
    cmd.ins = accept && (kind_i == KIND_INSERT) && !full;
    cmd.rem = accept && (kind_i == KIND_REMOVE) && !empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_before;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_before = 1'b1;
      assign left_entry  = cmd.new_entry;
    end else begin : g_body
      assign left_before = ahead[i-1];
      assign left_entry  = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (count_q > CntW'(i)),
      .cmd_i         (cmd),
      .left_before_i (left_before),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .before_o      (ahead[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    status_d   = status_q;
    out_tag_d  = out_tag_q;
    out_prio_d = out_prio_q;
    if (accept) begin
      out_tag_d  = '0;
      out_prio_d = '0;
      if (kind_i == KIND_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d   = ST_REMOVED;
          out_tag_d  = cell_entry[0].tag;
          out_prio_d = cell_entry[0].prio;
          count_d    = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    out_tag_q  <= out_tag_d;
    out_prio_q <= out_prio_d;
  end

  assign cnt_ext        = {{OccW{1'b0}}, count_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_tag_o      = out_tag_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = cnt_ext[OccW-1:0];

endmodule

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     occupied_i,
  input  spq_cmd_t cmd_i,
  input  logic     left_before_i,
  input  entry_t   left_entry_i,
  input  entry_t   right_entry_i,
  output logic     before_o,
  output entry_t   entry_o
);

  entry_t entry_q, entry_d;

  assign entry_o  = entry_q;
  assign before_o = occupied_i &&
                    ((entry_q.prio < cmd_i.new_entry.prio) ||
                     ((entry_q.prio == cmd_i.new_entry.prio) &&
                      (entry_q.order <= cmd_i.new_entry.order)));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!before_o) begin
        entry_d = left_before_i ? cmd_i.new_entry : left_entry_i;
      end
    end else if (cmd_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
